// File: src/lfd_pkg.sv
`default_nettype none

package lfd_pkg;

  localparam int unsigned HeaderBytes = 20;
  localparam int unsigned MaxPayload  = 4096;

  // Byte position within a frame: header plus the largest payload that passes the size check.
  localparam int unsigned PosW = $clog2(HeaderBytes + MaxPayload + 1);

  // Header layout, byte positions.
  localparam int unsigned PosMagicLast = 3;
  localparam int unsigned PosVersion   = 4;
  localparam int unsigned PosHdrLen    = 5;
  localparam int unsigned PosFieldLast = 13;
  localparam int unsigned PosLenLow    = 14;
  localparam int unsigned PosLenHigh   = 15;
  localparam int unsigned PosCrcFirst  = 16;
  localparam int unsigned PosFieldFirst = 6;

  localparam int unsigned ConsumedW = 17;

  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  localparam logic [15:0] LimitReset = 16'd4096;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INCOMPLETE  = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_BAD_HDRLEN  = 3'd4,
    ST_TOO_LARGE   = 3'd5,
    ST_BAD_CRC     = 3'd6
  } lfd_status_e;

  typedef enum logic [1:0] {
    CFG_MAGIC   = 2'd0,
    CFG_VERSION = 2'd1,
    CFG_LIMIT   = 2'd2
  } lfd_cfg_reg_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } lfd_kind_e;

  typedef struct packed {
    lfd_kind_e             item_kind;
    logic [7:0]            payload_byte;
    lfd_status_e           status;
    logic [7:0]            msg_type;
    logic [7:0]            channel_id;
    logic [15:0]           frame_flags;
    logic [15:0]           seq_number;
    logic [15:0]           ack_number;
    logic [ConsumedW-1:0]  frame_len;
  } lfd_result_t;

  // Reflected CRC-32, one byte per call, eight bit steps unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h00_0000, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/lfd_if.sv
`default_nettype none

interface lfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface lfd_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [7:0]  msg_type;
  logic [7:0]  channel_id;
  logic [15:0] frame_flags;
  logic [15:0] seq_number;
  logic [15:0] ack_number;
  logic [16:0] frame_len;

  modport source (output valid, output item_kind, output payload_byte, output status,
                  output msg_type, output channel_id, output frame_flags,
                  output seq_number, output ack_number, output frame_len,
                  input ready);
  modport sink   (input valid, input item_kind, input payload_byte, input status,
                  input msg_type, input channel_id, input frame_flags,
                  input seq_number, input ack_number, input frame_len,
                  output ready);
endinterface

interface lfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// File: src/lfd_out_buf.sv
`default_nettype none

module lfd_out_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire lfd_pkg::lfd_result_t push_data_i,
  output logic                      full_o,
  output logic                      pop_valid_o,
  output lfd_pkg::lfd_result_t      pop_data_o,
  input  wire logic                 pop_ready_i
);
  import lfd_pkg::*;

  lfd_result_t slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        pop;

  assign full_o      = (count_q == 2'd2);
  assign pop_valid_o = (count_q != 2'd0);
  assign pop_data_o  = slot_q[rd_ptr_q];
  assign pop         = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/link_frame_decoder.sv
`default_nettype none

// Channel   Dir  Handshake     Word
// in_i      in   valid/ready   rx_byte, buffer_end
// out_o     out  valid/ready   item_kind, payload_byte, status, header fields, frame_len
// cfg_i     in   valid/ready   reg_index, wdata (ready held high)
//
// One byte is taken per cycle. Its parse, CRC update and checks finish in the cycle it is
// taken; a result word lands in a two-word output queue, so a byte is still taken while
// one result waits. in_i.ready drops only while both queue words are held.
// Reset clears the frame position, error and drop state and the queue, presets the CRC to
// all ones and sets the payload limit to 4096; magic and version reset to zero.

module link_frame_decoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lfd_in_if.sink    in_i,
  lfd_out_if.source out_o,
  lfd_cfg_if.sink   cfg_i
);
  import lfd_pkg::*;

  // Configuration registers.
  logic [31:0] magic_q;
  logic [7:0]  version_q;
  logic [15:0] limit_q;

  // Frame state.
  logic [PosW-1:0]  pos_q, pos_d;
  logic [31:0]      crc_q, crc_d;
  lfd_status_e      perr_q, perr_d;
  logic             drop_q, drop_d;
  logic [15:0]      plen_q, plen_d;
  logic [7:0][7:0]  hdr_q, hdr_d;
  logic [3:0][7:0]  rcv_q, rcv_d;
  logic [2:0][7:0]  mag_q, mag_d;

  logic             accept;
  logic             in_hdr;
  logic             start;
  logic [PosW-1:0]  pos_inc;
  logic [31:0]      crc_feed;
  logic             res_valid;
  lfd_result_t      res;
  logic             full;
  logic             head_valid;
  lfd_result_t      head;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = !full;
  assign cfg_i.ready = 1'b1;
  assign in_hdr      = (pos_q < PosW'(HeaderBytes));
  assign pos_inc     = pos_q + PosW'(1);
  // Header CRC bytes count as zero in the checksum.
  assign crc_feed    = crc_byte(crc_q,
                                (in_hdr && pos_q >= PosW'(PosCrcFirst)) ? 8'h00 : in_i.rx_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      version_q <= '0;
      limit_q   <= LimitReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CFG_MAGIC:   magic_q   <= cfg_i.wdata;
        CFG_VERSION: version_q <= cfg_i.wdata[7:0];
        CFG_LIMIT:   limit_q   <= cfg_i.wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    perr_d    = perr_q;
    drop_d    = drop_q;
    plen_d    = plen_q;
    hdr_d     = hdr_q;
    rcv_d     = rcv_q;
    mag_d     = mag_q;
    res_valid = 1'b0;
    res       = '0;
    start     = 1'b0;

    if (accept) begin
      if (drop_q) begin
        // Drop everything up to and including the next buffer-end byte.
        if (in_i.buffer_end) begin
          drop_d = 1'b0;
          start  = 1'b1;
        end
      end else if (in_hdr) begin
        crc_d = crc_feed;
        pos_d = pos_inc;
        priority if (pos_q < PosW'(PosMagicLast)) begin
          mag_d[2'(pos_q)] = in_i.rx_byte;
        end else if (pos_q == PosW'(PosMagicLast)) begin
          if ({in_i.rx_byte, mag_q[2], mag_q[1], mag_q[0]} != magic_q && perr_q == ST_OK) begin
            perr_d = ST_BAD_MAGIC;
          end
        end else if (pos_q == PosW'(PosVersion)) begin
          if (in_i.rx_byte != version_q && perr_q == ST_OK) begin
            perr_d = ST_BAD_VERSION;
          end
        end else if (pos_q == PosW'(PosHdrLen)) begin
          if (in_i.rx_byte != 8'(HeaderBytes) && perr_q == ST_OK) begin
            perr_d = ST_BAD_HDRLEN;
          end
        end else if (pos_q <= PosW'(PosFieldLast)) begin
          hdr_d[3'(pos_q - PosW'(PosFieldFirst))] = in_i.rx_byte;
        end else if (pos_q == PosW'(PosLenLow)) begin
          plen_d = {8'h00, in_i.rx_byte};
        end else if (pos_q == PosW'(PosLenHigh)) begin
          plen_d = {in_i.rx_byte, plen_q[7:0]};
          if ((plen_d > limit_q || plen_d > 16'(MaxPayload)) && perr_q == ST_OK) begin
            perr_d = ST_TOO_LARGE;
          end
        end else begin
          rcv_d[2'(pos_q - PosW'(PosCrcFirst))] = in_i.rx_byte;
        end

        priority if (pos_q != PosW'(HeaderBytes - 1)) begin
          // Header cut short: faults wait until all header bytes are in.
          if (in_i.buffer_end) begin
            res_valid      = 1'b1;
            res.item_kind  = KIND_STATUS;
            res.status     = ST_INCOMPLETE;
            start          = 1'b1;
          end
        end else if (perr_d != ST_OK) begin
          res_valid     = 1'b1;
          res.item_kind = KIND_STATUS;
          res.status    = perr_d;
          drop_d        = !in_i.buffer_end;
          start         = 1'b1;
        end else if (plen_q == 16'h0000) begin
          // Empty payload: the frame closes on the last header byte.
          res_valid     = 1'b1;
          res.item_kind = KIND_STATUS;
          res.status    = (~crc_d == rcv_d) ? ST_OK : ST_BAD_CRC;
          drop_d        = (res.status != ST_OK) && !in_i.buffer_end;
          start         = 1'b1;
        end else if (in_i.buffer_end) begin
          res_valid     = 1'b1;
          res.item_kind = KIND_STATUS;
          res.status    = ST_INCOMPLETE;
          start         = 1'b1;
        end
      end else begin
        crc_d     = crc_feed;
        pos_d     = pos_inc;
        res_valid = 1'b1;
        priority if ({{(ConsumedW - PosW){1'b0}}, pos_inc} >=
                     ConsumedW'(HeaderBytes) + {1'b0, plen_q}) begin
          // Last payload byte rides on the status word.
          res.item_kind    = KIND_STATUS;
          res.payload_byte = in_i.rx_byte;
          res.status       = (~crc_d == rcv_q) ? ST_OK : ST_BAD_CRC;
          drop_d           = (res.status != ST_OK) && !in_i.buffer_end;
          start            = 1'b1;
        end else if (in_i.buffer_end) begin
          res.item_kind = KIND_STATUS;
          res.status    = ST_INCOMPLETE;
          start         = 1'b1;
        end else begin
          res.item_kind    = KIND_PAYLOAD;
          res.payload_byte = in_i.rx_byte;
        end
      end

      // Header fields and length travel only with a good frame.
      if (res_valid && res.item_kind == KIND_STATUS && res.status == ST_OK) begin
        res.msg_type    = hdr_q[0];
        res.channel_id  = hdr_q[1];
        res.frame_flags = {hdr_q[3], hdr_q[2]};
        res.seq_number  = {hdr_q[5], hdr_q[4]};
        res.ack_number  = {hdr_q[7], hdr_q[6]};
        res.frame_len   = {{(ConsumedW - PosW){1'b0}}, pos_inc};
      end

      if (start) begin
        pos_d  = '0;
        crc_d  = CrcInit;
        perr_d = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= CrcInit;
      perr_q <= ST_OK;
      drop_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      perr_q <= perr_d;
      drop_q <= drop_d;
    end
  end

  // Header payload registers: every byte is rewritten before it is read.
  always_ff @(posedge clk_i) begin
    plen_q <= plen_d;
    hdr_q  <= hdr_d;
    rcv_q  <= rcv_d;
    mag_q  <= mag_d;
  end

  lfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .pop_valid_o (head_valid),
    .pop_data_o  (head),
    .pop_ready_i (out_o.ready)
  );

  assign out_o.valid        = head_valid;
  assign out_o.item_kind    = head.item_kind;
  assign out_o.payload_byte = head.payload_byte;
  assign out_o.status       = head.status;
  assign out_o.msg_type     = head.msg_type;
  assign out_o.channel_id   = head.channel_id;
  assign out_o.frame_flags  = head.frame_flags;
  assign out_o.seq_number   = head.seq_number;
  assign out_o.ack_number   = head.ack_number;
  assign out_o.frame_len    = head.frame_len;

endmodule

`default_nettype wire
